// ----- sv/rgb_luma_laplacian_3x3_defines.svh -----
// ----------------------------------------------------------------------------
// rgb_luma_laplacian_3x3_defines
// Assertion macros used by the Laplacian edge filter RTL.
// ----------------------------------------------------------------------------
`ifndef RGB_LUMA_LAPLACIAN_3X3_DEFINES_SVH
`define RGB_LUMA_LAPLACIAN_3X3_DEFINES_SVH

`ifndef ASSERT_OFF
`define RLL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define RLL_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RLL_ASSERT(label, prop, msg)
`define RLL_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

// ----- sv/rll_pkg.sv -----
// ----------------------------------------------------------------------------
// rll_pkg
// Types, constants and helpers of the RGB luma Laplacian edge filter.
// ----------------------------------------------------------------------------
package rll_pkg;

  localparam int PIXEL_W        = 24;
  localparam int LUMA_W         = 8;
  localparam int LINE_WIDTH_W   = 11;
  localparam int FRAME_HEIGHT_W = 13;
  localparam int APB_ADDR_W     = 3;
  localparam int APB_DATA_W     = 32;
  localparam int LAP_W          = 12;

  localparam int DEF_MAX_LINE_WIDTH   = 1024;
  localparam int DEF_MAX_FRAME_HEIGHT = 4096;
  localparam int MIN_SIZE             = 3;
  localparam int BORDER               = 2;

  localparam logic [LINE_WIDTH_W-1:0]   RESET_LINE_WIDTH   = 11'd64;
  localparam logic [FRAME_HEIGHT_W-1:0] RESET_FRAME_HEIGHT = 13'd48;

  localparam logic [15:0] COEF_R = 16'd77;
  localparam logic [15:0] COEF_G = 16'd150;
  localparam logic [15:0] COEF_B = 16'd29;
  localparam logic [LUMA_W-1:0] LUMA_MAX = 8'hff;

  typedef enum logic {
    REG_LINE_WIDTH   = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic rd;
    logic wr;
  } ls_ctrl_t;

  typedef struct packed {
    logic [LUMA_W-1:0] older;
    logic [LUMA_W-1:0] previous;
  } lines_t;

  function automatic logic [LUMA_W-1:0] luma_of(input logic [PIXEL_W-1:0] rgb);
    logic [15:0] sum;
    sum = COEF_R * 16'(rgb[23:16]) + COEF_G * 16'(rgb[15:8]) + COEF_B * 16'(rgb[7:0]);
    return sum[15:8];
  endfunction

endpackage

// ----- sv/rll_in_if.sv -----
// ----------------------------------------------------------------------------
// rll_in_if
// Input pixel channel: valid/ready handshake with RGB pixel and frame start.
// ----------------------------------------------------------------------------
interface rll_in_if;
  import rll_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] pixel_rgb;
  logic               start_of_frame;

  modport source (output valid, output pixel_rgb, output start_of_frame, input ready);
  modport sink   (input valid, input pixel_rgb, input start_of_frame, output ready);
endinterface

// ----- sv/rll_out_if.sv -----
// ----------------------------------------------------------------------------
// rll_out_if
// Output pixel channel: valid/ready handshake with edge pixel and frame end.
// ----------------------------------------------------------------------------
interface rll_out_if;
  import rll_pkg::*;

  logic               valid;
  logic               ready;
  logic [PIXEL_W-1:0] edge_pixel;
  logic               end_of_frame;

  modport source (output valid, output edge_pixel, output end_of_frame, input ready);
  modport sink   (input valid, input edge_pixel, input end_of_frame, output ready);
endinterface

// ----- sv/rgb_luma_laplacian_3x3.sv -----
// Pipeline: a single pipeline stage (s1) plus the output register, in that order.
// One pixel per cycle, unless the output stalls or the line memories are busy.
// Reset: synchronous; control state clears and the line memories are zeroed by a
// sweep of all MAX_LINE_WIDTH addresses (1024 by default), taking no pixel.
// Configuration writes are accepted at any time, also during that sweep.
// ----------------------------------------------------------------------------
// rgb_luma_laplacian_3x3
// RGB to luma conversion and 3x3 Laplacian edge filter over a raster stream.
// ----------------------------------------------------------------------------
`include "rgb_luma_laplacian_3x3_defines.svh"

module rgb_luma_laplacian_3x3 #(
  parameter int MAX_LINE_WIDTH   = rll_pkg::DEF_MAX_LINE_WIDTH,
  parameter int MAX_FRAME_HEIGHT = rll_pkg::DEF_MAX_FRAME_HEIGHT
) (
  input  logic                          clk,
  input  logic                          rst,
  rll_in_if.sink                        pix_in,
  rll_out_if.source                     pix_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rll_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [rll_pkg::APB_DATA_W-1:0] pwdata,
  output logic [rll_pkg::APB_DATA_W-1:0] prdata,
  output logic                          pready
);
  import rll_pkg::*;

  localparam int COL_W  = $clog2(MAX_LINE_WIDTH);
  localparam int ROW_W  = $clog2(MAX_FRAME_HEIGHT);
  localparam int LWC_W  = $clog2(MAX_LINE_WIDTH + 1);
  localparam int FHC_W  = $clog2(MAX_FRAME_HEIGHT + 1);
  localparam int LW_W   = (LWC_W > LINE_WIDTH_W) ? LWC_W : LINE_WIDTH_W;
  localparam int FH_W   = (FHC_W > FRAME_HEIGHT_W) ? FHC_W : FRAME_HEIGHT_W;

  // configuration
  logic [LINE_WIDTH_W-1:0]   line_width;
  logic [FRAME_HEIGHT_W-1:0] frame_height;
  logic                      cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= RESET_LINE_WIDTH;
      frame_height <= RESET_FRAME_HEIGHT;
    end else if (cfg_wr) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_LINE_WIDTH:   line_width   <= pwdata[LINE_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[FRAME_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_LINE_WIDTH:   prdata = APB_DATA_W'(line_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // effective frame size
  logic [LW_W-1:0] lw_ext;
  logic [LW_W-1:0] w_eff;
  logic [FH_W-1:0] fh_ext;
  logic [FH_W-1:0] h_eff;

  assign lw_ext = LW_W'(line_width);
  assign fh_ext = FH_W'(frame_height);

  always_comb begin
    priority if (lw_ext < LW_W'(MIN_SIZE)) begin
      w_eff = LW_W'(MIN_SIZE);
    end else if (lw_ext > LW_W'(MAX_LINE_WIDTH)) begin
      w_eff = LW_W'(MAX_LINE_WIDTH);
    end else begin
      w_eff = lw_ext;
    end
    priority if (fh_ext < FH_W'(MIN_SIZE)) begin
      h_eff = FH_W'(MIN_SIZE);
    end else if (fh_ext > FH_W'(MAX_FRAME_HEIGHT)) begin
      h_eff = FH_W'(MAX_FRAME_HEIGHT);
    end else begin
      h_eff = fh_ext;
    end
  end

  // input side: position counters
  logic [COL_W-1:0] column_count;
  logic [ROW_W-1:0] row_count;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;
  logic             last_col;
  logic             last_row;
  logic             border;
  logic             accept;
  logic             busy;

  logic              s1_valid;
  logic              s1_adv;
  logic [COL_W-1:0]  s1_col;
  logic [LUMA_W-1:0] s1_luma;
  logic              s1_border;
  logic              s1_eof;

  assign s1_adv       = !pix_out.valid || pix_out.ready;
  assign pix_in.ready = !busy && (!s1_valid || s1_adv);
  assign accept       = pix_in.valid && pix_in.ready;

  assign col_cur  = pix_in.start_of_frame ? '0 : column_count;
  assign row_cur  = pix_in.start_of_frame ? '0 : row_count;
  assign last_col = (LW_W'(col_cur) + LW_W'(1)) >= w_eff;
  assign last_row = (FH_W'(row_cur) + FH_W'(1)) >= h_eff;
  assign border   = (col_cur < COL_W'(BORDER)) || (row_cur < ROW_W'(BORDER));

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= last_row ? '0 : row_cur + ROW_W'(1);
      end else begin
        column_count <= col_cur + COL_W'(1);
        row_count    <= row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col    <= col_cur;
      s1_luma   <= luma_of(pix_in.pixel_rgb);
      s1_border <= border;
      s1_eof    <= last_col && last_row;
    end
  end

  // line memories
  ls_ctrl_t ls_ctrl;
  lines_t   ls_col;

  assign ls_ctrl.rd = accept;
  assign ls_ctrl.wr = s1_valid && s1_adv;

  rll_line_store #(
    .DEPTH (MAX_LINE_WIDTH)
  ) u_line_store (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ls_ctrl),
    .rd_addr (col_cur),
    .wr_addr (s1_col),
    .wr_luma (s1_luma),
    .rd_col  (ls_col),
    .busy    (busy)
  );

  // 3x3 window: two stored columns plus the incoming one
  logic [LUMA_W-1:0] win_a [3];
  logic [LUMA_W-1:0] win_b [3];
  logic [LUMA_W-1:0] win_c [3];
  logic [LUMA_W+2:0] ring_sum;
  logic signed [LAP_W-1:0] lap;
  logic [LUMA_W-1:0] lap_clamped;

  assign win_c[0] = ls_col.older;
  assign win_c[1] = ls_col.previous;
  assign win_c[2] = s1_luma;

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        win_a[r] <= win_b[r];
        win_b[r] <= win_c[r];
      end
    end
  end

  assign ring_sum = (LUMA_W+3)'(win_a[0]) + (LUMA_W+3)'(win_a[1]) + (LUMA_W+3)'(win_a[2])
                  + (LUMA_W+3)'(win_b[0]) + (LUMA_W+3)'(win_b[2])
                  + (LUMA_W+3)'(win_c[0]) + (LUMA_W+3)'(win_c[1]) + (LUMA_W+3)'(win_c[2]);
  assign lap = $signed({1'b0, win_b[1], 3'b000}) - $signed({1'b0, ring_sum});

  always_comb begin
    priority if (lap[LAP_W-1]) begin
      lap_clamped = '0;
    end else if (|lap[LAP_W-2:LUMA_W]) begin
      lap_clamped = LUMA_MAX;
    end else begin
      lap_clamped = lap[LUMA_W-1:0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pix_out.valid <= 1'b0;
    end else if (s1_adv) begin
      pix_out.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      pix_out.edge_pixel   <= s1_border ? '0 : {lap_clamped, lap_clamped, lap_clamped};
      pix_out.end_of_frame <= s1_eof;
    end
  end

  `RLL_ASSERT(a_clear_empty, $fell(busy) |-> (!s1_valid && !pix_out.valid), "items in flight during memory clear")
  `RLL_ASSERT_NEXT(a_stage_to_out, s1_valid && s1_adv, pix_out.valid, "advancing item lost before output")
  `RLL_ASSERT_NEXT(a_stage_hold, s1_valid && !s1_adv, s1_valid && $stable(s1_col), "stalled item not held")
  `RLL_ASSERT_NEXT(a_sof_origin, accept && pix_in.start_of_frame, column_count == COL_W'(1), "frame start did not restart column count")

endmodule

// ----- sv/rll_line_store.sv -----
// ----------------------------------------------------------------------------
// rll_line_store
// Two luma line memories (lines y-2 and y-1) with registered read, bypass of
// the write landing on the same column, and a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module rll_line_store #(
  parameter int DEPTH = rll_pkg::DEF_MAX_LINE_WIDTH,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  rll_pkg::ls_ctrl_t        ctrl,
  input  logic [AW-1:0]            rd_addr,
  input  logic [AW-1:0]            wr_addr,
  input  logic [rll_pkg::LUMA_W-1:0] wr_luma,
  output rll_pkg::lines_t          rd_col,
  output logic                     busy
);
  import rll_pkg::*;

  logic [LUMA_W-1:0] mem_older [DEPTH];
  logic [LUMA_W-1:0] mem_prev  [DEPTH];

  logic [LUMA_W-1:0] rd_older;
  logic [LUMA_W-1:0] rd_prev;
  logic              fwd;
  logic [LUMA_W-1:0] fwd_older;
  logic [LUMA_W-1:0] fwd_prev;
  logic [AW-1:0]     clear_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b1;
      clear_addr <= '0;
    end else if (busy) begin
      clear_addr <= clear_addr + AW'(1);
      if (clear_addr == AW'(DEPTH - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      mem_older[clear_addr] <= '0;
      mem_prev[clear_addr]  <= '0;
    end else if (ctrl.wr) begin
      mem_older[wr_addr] <= rd_col.previous;
      mem_prev[wr_addr]  <= wr_luma;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.rd) begin
      rd_older  <= mem_older[rd_addr];
      rd_prev   <= mem_prev[rd_addr];
      fwd_older <= rd_col.previous;
      fwd_prev  <= wr_luma;
    end
  end

  // write in flight to the column being read: take its data instead
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd <= 1'b0;
    end else if (ctrl.rd) begin
      fwd <= ctrl.wr && (wr_addr == rd_addr);
    end
  end

  assign rd_col.older    = fwd ? fwd_older : rd_older;
  assign rd_col.previous = fwd ? fwd_prev  : rd_prev;

endmodule
